// ===== src/llrp_pkg.sv =====
// ============================================================================
// llrp_pkg
// Shared types, constants and the schedulability bound table generator for
// the least-loaded rate-monotonic task partitioner.
// ============================================================================
package llrp_pkg;

  // fixed field widths
  localparam int TIME_W     = 10;
  localparam int LOAD_W     = 23;
  localparam int UTIL_W     = 17;
  localparam int FRAC_BITS  = 16;
  localparam int PROC_OUT_W = 2;
  localparam int CNT_OUT_W  = 7;
  localparam int CFG_W      = 3;
  localparam int QDEPTH     = 2;

  localparam logic [LOAD_W-1:0] LOAD_MAX   = {LOAD_W{1'b1}};
  localparam logic [CFG_W-1:0]  CFG_RESET  = 3'd4;
  localparam logic [UTIL_W-1:0] UTIL_ONE   = 17'h10000;

  // result status codes
  typedef enum logic [1:0] {
    ST_ASSIGNED    = 2'd0,
    ST_ZERO_PERIOD = 2'd1,
    ST_COST_OVER   = 2'd2,
    ST_FULL        = 2'd3
  } status_e;

  // back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_CHECK,
    BK_EMIT
  } back_state_e;

  // input request
  typedef struct packed {
    logic              start_new_set;
    logic [TIME_W-1:0] exec_cost;
    logic [TIME_W-1:0] task_period;
  } task_in_t;

  // result
  typedef struct packed {
    status_e              status;
    logic [PROC_OUT_W-1:0] assigned_processor;
    logic [LOAD_W-1:0]    processor_utilization;
    logic [CNT_OUT_W-1:0] processor_task_count;
    logic                 within_bound;
  } task_out_t;

  // classified request held in the queue between front and back
  typedef struct packed {
    logic              clear;
    status_e           kind;
    logic [TIME_W-1:0] cost;
    logic [TIME_W-1:0] period;
  } task_req_t;

  // floor(65536 * n * (2^(1/n) - 1)), evaluated at elaboration only
  // 2^(1/n) is found by bisection on x^n <= 2
  function automatic int unsigned ll_bound_f(int unsigned n);
    real lo;
    real hi;
    real mid;
    real pw;
    if (n <= 1) begin
      return 65536;
    end
    lo = 1.0;
    hi = 2.0;
    for (int k = 0; k < 60; k++) begin
      mid = (lo + hi) * 0.5;
      pw  = 1.0;
      for (int unsigned j = 0; j < n; j++) begin
        pw = pw * mid;
      end
      if (pw <= 2.0) begin
        lo = mid;
      end else begin
        hi = mid;
      end
    end
    return $rtoi(65536.0 * real'(n) * (lo - 1.0));
  endfunction

endpackage

// ===== src/llrp_front.sv =====
// ============================================================================
// llrp_front
// Accepts task requests, masks the time fields, classifies zero period and
// cost-over-period errors, and buffers them in a two-entry queue.
// ============================================================================
module llrp_front #(
  parameter int TIME_BITS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  llrp_pkg::task_in_t task_i,
  output logic               full_o,
  output logic               req_valid_o,
  output llrp_pkg::task_req_t req_o,
  input  logic               deq_i
);
  import llrp_pkg::*;

  localparam int CW = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;
  localparam logic [TIME_W-1:0] TMASK = TIME_W'((64'd1 << CW) - 64'd1);
  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  task_req_t           entry_q [QDEPTH];
  logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]    count_q;
  task_req_t           cls;
  logic                enq, deq;

  // classify the incoming request
  always_comb begin
    cls.clear  = task_i.start_new_set;
    cls.cost   = task_i.exec_cost & TMASK;
    cls.period = task_i.task_period & TMASK;
    if (cls.period == '0) begin
      cls.kind = ST_ZERO_PERIOD;
    end else if (cls.cost > cls.period) begin
      cls.kind = ST_COST_OVER;
    end else begin
      cls.kind = ST_ASSIGNED;
    end
  end

  assign full_o      = (count_q == CNT_W'(QDEPTH));
  assign req_valid_o = (count_q != '0);
  assign req_o       = entry_q[rd_ptr_q];
  assign enq         = push_i && !full_o;
  assign deq         = deq_i && req_valid_o;

  // queue storage
  always_ff @(posedge clk_i) begin
    if (enq) begin
      entry_q[wr_ptr_q] <= cls;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (enq) begin
        wr_ptr_q <= PTR_W'((32'(wr_ptr_q) + 1) % QDEPTH);
      end
      if (deq) begin
        rd_ptr_q <= PTR_W'((32'(rd_ptr_q) + 1) % QDEPTH);
      end
      if (enq && !deq) begin
        count_q <= count_q + 1'b1;
      end else if (deq && !enq) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== src/llrp_div.sv =====
// ============================================================================
// llrp_div
// Bit-serial restoring divider for (cost << 16) / period with cost <= period,
// one quotient bit per cycle.
// ============================================================================
module llrp_div #(
  parameter int VAL_W = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [VAL_W-1:0]           dividend_i,
  input  logic [VAL_W-1:0]           divisor_i,
  output logic                       busy_o,
  output logic [llrp_pkg::UTIL_W-1:0] quotient_o
);
  import llrp_pkg::*;

  localparam int STEP_W = $clog2(UTIL_W);

  logic [VAL_W-1:0]  rem_q, rem_d;
  logic [VAL_W-1:0]  div_q;
  logic [UTIL_W-1:0] quo_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q;
  logic [VAL_W:0]    trial;
  logic              ge;

  // one restoring step: the first step compares without shifting
  always_comb begin
    trial = (step_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
    ge    = (trial >= {1'b0, div_q});
    rem_d = ge ? VAL_W'(trial - {1'b0, div_q}) : VAL_W'(trial);
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i;
      div_q <= divisor_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[UTIL_W-2:0], ge};
    end
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      if (step_q == STEP_W'(UTIL_W - 1)) begin
        busy_q <= 1'b0;
      end else begin
        step_q <= step_q + 1'b1;
      end
    end
  end

endmodule

// ===== src/llrp_back.sv =====
// ============================================================================
// llrp_back
// Carries out queued requests: least-loaded search over the active
// processors alongside the divider, load and count update, bound check and
// the result register.
// ============================================================================
module llrp_back #(
  parameter int PROCESSORS              = 4,
  parameter int MAX_TASKS_PER_PROCESSOR = 64,
  parameter int VAL_W                   = 10
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic [$clog2(PROCESSORS+1)-1:0]         act_i,
  input  logic                                    req_valid_i,
  input  llrp_pkg::task_req_t                     req_i,
  output logic                                    deq_o,
  input  logic                                    pop_i,
  output logic                                    empty_o,
  output llrp_pkg::task_out_t                     result_o
);
  import llrp_pkg::*;

  localparam int AW   = $clog2(PROCESSORS + 1);
  localparam int PW   = (PROCESSORS > 1) ? $clog2(PROCESSORS) : 1;
  localparam int CNTW = $clog2(MAX_TASKS_PER_PROCESSOR + 1);
  localparam logic [CNTW-1:0] CNT_MAX = CNTW'(MAX_TASKS_PER_PROCESSOR);

  back_state_e       state_q, state_d;
  logic [LOAD_W-1:0] loads_q [PROCESSORS];
  logic [CNTW-1:0]   tasks_q [PROCESSORS];
  logic [UTIL_W-1:0] bound_tab [MAX_TASKS_PER_PROCESSOR+1];

  status_e           status_q;
  logic [PW-1:0]     best_idx_q;
  logic [LOAD_W-1:0] best_load_q;
  logic [AW-1:0]     scan_idx_q;
  logic [LOAD_W-1:0] total_q;
  logic [CNTW-1:0]   cnt_q;
  task_out_t         out_q, out_d;
  logic              out_valid_q;

  logic              deq, div_start, commit_chk, emit, scan_done;
  logic              div_busy;
  logic [UTIL_W-1:0] util;
  logic [LOAD_W-1:0] scan_load;
  logic [LOAD_W:0]   sum;
  logic [LOAD_W-1:0] total_sat;
  logic              proc_full;

  // bound table, one entry per task count
  for (genvar g = 0; g <= MAX_TASKS_PER_PROCESSOR; g++) begin : g_bound
    assign bound_tab[g] = UTIL_W'(ll_bound_f(g));
  end

  // utilization divider
  llrp_div #(
    .VAL_W(VAL_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(req_i.cost[VAL_W-1:0]),
    .divisor_i (req_i.period[VAL_W-1:0]),
    .busy_o    (div_busy),
    .quotient_o(util)
  );

  assign scan_load = loads_q[scan_idx_q[PW-1:0]];
  assign scan_done = (scan_idx_q >= act_i);
  assign sum       = {1'b0, best_load_q} + (LOAD_W+1)'(util);
  assign total_sat = sum[LOAD_W] ? LOAD_MAX : sum[LOAD_W-1:0];
  assign proc_full = (tasks_q[best_idx_q] >= CNT_MAX);
  assign deq_o     = deq;
  assign empty_o   = !out_valid_q;
  assign result_o  = out_q;

  // sequencer next state and controls
  always_comb begin
    state_d    = state_q;
    deq        = 1'b0;
    div_start  = 1'b0;
    commit_chk = 1'b0;
    emit       = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (req_valid_i) begin
          deq = 1'b1;
          if (req_i.kind == ST_ASSIGNED) begin
            div_start = 1'b1;
            state_d   = BK_RUN;
          end else begin
            state_d = BK_EMIT;
          end
        end
      end
      BK_RUN: begin
        if (!div_busy && scan_done) begin
          state_d = BK_CHECK;
        end
      end
      BK_CHECK: begin
        commit_chk = 1'b1;
        state_d    = BK_EMIT;
      end
      BK_EMIT: begin
        if (!out_valid_q || pop_i) begin
          emit    = 1'b1;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // result formatting
  always_comb begin
    out_d        = '0;
    out_d.status = status_q;
    if (status_q == ST_ASSIGNED) begin
      out_d.assigned_processor    = PROC_OUT_W'(best_idx_q);
      out_d.processor_utilization = total_q;
      out_d.processor_task_count  = CNT_OUT_W'(cnt_q);
      out_d.within_bound          = (total_q <= LOAD_W'(bound_tab[cnt_q]));
    end
  end

  // request working registers
  always_ff @(posedge clk_i) begin
    if (deq) begin
      status_q    <= req_i.kind;
      best_idx_q  <= '0;
      best_load_q <= req_i.clear ? '0 : loads_q[0];
      scan_idx_q  <= AW'(1);
    end else if (state_q == BK_RUN) begin
      if (!scan_done) begin
        if (scan_load < best_load_q) begin
          best_load_q <= scan_load;
          best_idx_q  <= scan_idx_q[PW-1:0];
        end
        scan_idx_q <= scan_idx_q + 1'b1;
      end
    end else if (commit_chk) begin
      if (proc_full) begin
        status_q <= ST_FULL;
      end else begin
        total_q <= total_sat;
        cnt_q   <= tasks_q[best_idx_q] + 1'b1;
      end
    end
  end

  // per-processor load and task count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PROCESSORS; i++) begin
        loads_q[i] <= '0;
        tasks_q[i] <= '0;
      end
    end else if (deq && req_i.clear) begin
      for (int i = 0; i < PROCESSORS; i++) begin
        loads_q[i] <= '0;
        tasks_q[i] <= '0;
      end
    end else if (commit_chk && !proc_full) begin
      loads_q[best_idx_q] <= total_sat;
      tasks_q[best_idx_q] <= tasks_q[best_idx_q] + 1'b1;
    end
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule

// ===== src/least_loaded_rms_task_partitioner.sv =====
// ============================================================================
// least_loaded_rms_task_partitioner
// Worst-fit partitioning of periodic tasks onto processors with a
// Liu-Layland utilization check per processor.
// ============================================================================
// Tasks enter through a two-entry request queue and are handled one at a
// time. A task that passes the period checks is dequeued, then runs the
// bit-serial utilization divider (one quotient bit per cycle), which also
// covers the least-loaded search, one processor per cycle. The sequencer
// then sees the divider finish, updates the chosen processor and loads the
// result register once it is free; when the chosen processor turns out
// to be full, it is not updated. A task rejected for a zero period or a
// cost above its period is dequeued and then emitted. Results wait in a
// one-entry output register while the queue keeps taking requests.
// Setting start_new_set clears every load and count before the task is
// handled, even when the task itself is rejected.
module least_loaded_rms_task_partitioner #(
  parameter int PROCESSORS              = 4,
  parameter int MAX_TASKS_PER_PROCESSOR = 64,
  parameter int TIME_BITS               = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  llrp_pkg::task_in_t            task_i,
  output logic                          empty,
  input  logic                          pop,
  output llrp_pkg::task_out_t           result_o,
  input  logic                          cfg_we_i,
  input  logic [llrp_pkg::CFG_W-1:0]    cfg_wdata_i
);
  import llrp_pkg::*;

  localparam int CW = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;
  localparam int AW = $clog2(PROCESSORS + 1);

  logic [CFG_W-1:0] active_q;
  logic [AW-1:0]    act;
  logic             req_valid, deq;
  task_req_t        req;

  // active processor count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      active_q <= cfg_wdata_i;
    end
  end

  // clamp to 1..PROCESSORS
  always_comb begin
    if (active_q == '0) begin
      act = AW'(1);
    end else if (32'(active_q) > PROCESSORS) begin
      act = AW'(PROCESSORS);
    end else begin
      act = AW'(active_q);
    end
  end

  llrp_front #(
    .TIME_BITS(TIME_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .task_i     (task_i),
    .full_o     (full),
    .req_valid_o(req_valid),
    .req_o      (req),
    .deq_i      (deq)
  );

  llrp_back #(
    .PROCESSORS             (PROCESSORS),
    .MAX_TASKS_PER_PROCESSOR(MAX_TASKS_PER_PROCESSOR),
    .VAL_W                  (CW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .act_i      (act),
    .req_valid_i(req_valid),
    .req_i      (req),
    .deq_o      (deq),
    .pop_i      (pop),
    .empty_o    (empty),
    .result_o   (result_o)
  );

endmodule

// ===== src/llrp_checker.sv =====
// ============================================================================
// llrp_checker
// Port-level checks on the partitioner's result channel, bound to the top.
// ============================================================================
module llrp_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       empty,
  input logic                       pop,
  input llrp_pkg::task_out_t        result_o
);
  import llrp_pkg::*;

  // a waiting result stays until taken
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result dropped before pop");

  // a waiting result does not change
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> $stable(result_o))
    else $error("result changed while waiting");

  // rejected requests carry no assignment
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.status != ST_ASSIGNED) |->
      (result_o.assigned_processor == '0 && result_o.processor_utilization == '0 &&
       result_o.processor_task_count == '0 && !result_o.within_bound))
    else $error("error result with nonzero fields");

  // an assignment always counts at least one task
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.status == ST_ASSIGNED) |-> result_o.processor_task_count != '0)
    else $error("assigned result with zero task count");

  // no bound exceeds full utilization
  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.within_bound) |->
      result_o.processor_utilization <= LOAD_W'(UTIL_ONE))
    else $error("within bound above full utilization");

endmodule

bind least_loaded_rms_task_partitioner llrp_checker u_llrp_checker (.*);

// ===== verif/tb_least_loaded_rms_task_partitioner.sv =====
// ============================================================================
// tb_least_loaded_rms_task_partitioner
// Self-checking testbench for the least-loaded rate-monotonic partitioner.
// ============================================================================
// Every accepted request is run through a behavioral copy of the partitioner:
// per-processor loads and task counts, the active processor count, the Q1.16
// utilization divide and the Liu-Layland test done as (1 + u/n)^n <= 2 in
// Q.62. The placement it predicts is queued and compared field by field with
// each result popped from the block. A short directed run covers the error
// priorities, clearing on a rejected task and the utilization extremes. Then
// come task sets under a sweep of active processor counts, 0 and 5..7 among
// them, with fill runs that push one processor to its task limit. Both sides
// idle at random.
module tb_least_loaded_rms_task_partitioner;
  import llrp_pkg::*;

  localparam int          PROC_COUNT  = 4;
  localparam int          TASK_LIMIT  = 64;
  localparam int          TARGET_REQS = 2000;
  localparam int unsigned LN2_Q16     = 45426;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      push        = 1'b0;
  logic      full;
  task_in_t  task_i      = '0;
  logic      empty;
  logic      pop         = 1'b0;
  task_out_t result_o;
  logic      cfg_we_i    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  // predictor state
  logic [LOAD_W-1:0]    proc_load  [PROC_COUNT];
  logic [CNT_OUT_W-1:0] proc_tasks [PROC_COUNT];
  logic [CFG_W-1:0]     active_count;

  task_in_t    task_backlog [$];
  task_out_t   expected_placements [$];
  logic        in_fire  = 1'b0;
  logic        out_fire = 1'b0;
  bit          calm;
  int unsigned idle_gap;
  int unsigned pop_hold;
  int unsigned mismatch_count;
  int unsigned request_total;

  least_loaded_rms_task_partitioner #(
    .PROCESSORS              (PROC_COUNT),
    .MAX_TASKS_PER_PROCESSOR (TASK_LIMIT),
    .TIME_BITS               (TIME_W)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .task_i      (task_i),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // idle length: mostly short, a few long, none while calm
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // (1 + u/(65536 n))^n <= 2 evaluated in Q.62, same as u <= floor(bound)
  function automatic logic rm_bound_ok(logic [LOAD_W-1:0] u, int unsigned n);
    logic [63:0]  step;
    logic [63:0]  power;
    logic [127:0] prod;
    if (n <= 1) return u <= LOAD_W'(65536);
    if (u > LOAD_W'(65536)) return 1'b0;
    if (u <= LOAD_W'(LN2_Q16)) return 1'b1;
    step  = (64'd1 << 62) + ((64'(u) << 46) / 64'(n));
    power = step;
    for (int unsigned i = 1; i < n; i++) begin
      prod  = 128'(power) * 128'(step);
      power = prod[125:62];
      if (power > (64'd1 << 63)) return 1'b0;
    end
    return 1'b1;
  endfunction

  // worst-fit placement of one task, updating loads and counts
  function automatic task_out_t place_task(task_in_t req);
    task_out_t   res;
    int unsigned active;
    int unsigned best;
    logic [25:0] scaled;
    logic [16:0] share;
    logic [23:0] sum;
    res = '0;
    if (req.start_new_set) begin
      for (int i = 0; i < PROC_COUNT; i++) begin
        proc_load[i]  = '0;
        proc_tasks[i] = '0;
      end
    end
    active = (active_count == 0) ? 1 :
             (active_count > PROC_COUNT) ? PROC_COUNT : int'(active_count);
    if (req.task_period == 0) begin
      res.status = ST_ZERO_PERIOD;
      return res;
    end
    if (req.exec_cost > req.task_period) begin
      res.status = ST_COST_OVER;
      return res;
    end
    best = 0;
    for (int unsigned i = 1; i < active; i++) begin
      if (proc_load[i] < proc_load[best]) best = i;
    end
    if (proc_tasks[best] >= TASK_LIMIT) begin
      res.status = ST_FULL;
      return res;
    end
    scaled = {req.exec_cost, 16'h0000};
    share  = 17'(scaled / 26'(req.task_period));
    sum    = {1'b0, proc_load[best]} + 24'(share);
    proc_load[best]  = (sum > 24'(LOAD_MAX)) ? LOAD_MAX : sum[LOAD_W-1:0];
    proc_tasks[best] = proc_tasks[best] + 1'b1;
    res.status                = ST_ASSIGNED;
    res.assigned_processor    = PROC_OUT_W'(best);
    res.processor_utilization = proc_load[best];
    res.processor_task_count  = proc_tasks[best];
    res.within_bound          = rm_bound_ok(proc_load[best], proc_tasks[best]);
    return res;
  endfunction

  // monitor: track handshakes, predict requests, check results
  always @(posedge clk_i) begin
    task_out_t want;
    if (!rst_ni) begin
      in_fire  <= 1'b0;
      out_fire <= 1'b0;
      active_count = CFG_RESET;
      for (int i = 0; i < PROC_COUNT; i++) begin
        proc_load[i]  = '0;
        proc_tasks[i] = '0;
      end
    end else begin
      in_fire  <= push && !full;
      out_fire <= pop && !empty;
      if (cfg_we_i) active_count = cfg_wdata_i;
      if (push && !full) expected_placements = {expected_placements, place_task(task_i)};
      if (pop && !empty) begin
        if (expected_placements.size() == 0) begin
          $error("unexpected result with no request waiting");
          mismatch_count++;
        end else begin
          want = expected_placements.pop_front();
          if (result_o.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, result_o.status);
            mismatch_count++;
          end
          if (result_o.assigned_processor !== want.assigned_processor) begin
            $error("assigned_processor: expected %0d, actual %0d",
                   want.assigned_processor, result_o.assigned_processor);
            mismatch_count++;
          end
          if (result_o.processor_utilization !== want.processor_utilization) begin
            $error("processor_utilization: expected %0d, actual %0d",
                   want.processor_utilization, result_o.processor_utilization);
            mismatch_count++;
          end
          if (result_o.processor_task_count !== want.processor_task_count) begin
            $error("processor_task_count: expected %0d, actual %0d",
                   want.processor_task_count, result_o.processor_task_count);
            mismatch_count++;
          end
          if (result_o.within_bound !== want.within_bound) begin
            $error("within_bound: expected %0d, actual %0d",
                   want.within_bound, result_o.within_bound);
            mismatch_count++;
          end
        end
      end
    end
  end

  // request driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else if (push && !in_fire) begin
      // request still waiting for a free slot
    end else if (idle_gap != 0) begin
      idle_gap--;
      push <= 1'b0;
    end else if (task_backlog.size() != 0) begin
      task_i   <= task_backlog.pop_front();
      push     <= 1'b1;
      idle_gap = pick_gap();
    end else begin
      push <= 1'b0;
    end
  end

  // result receiver with random stalls
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (out_fire) pop_hold = pick_gap();
      if (pop_hold != 0) begin
        pop_hold--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic queue_task(input bit fresh, input int unsigned cost,
                            input int unsigned period);
    task_in_t req;
    req.start_new_set = fresh;
    req.exec_cost     = TIME_W'(cost);
    req.task_period   = TIME_W'(period);
    task_backlog = {task_backlog, req};
    request_total++;
  endtask

  // random task: mostly valid, some rejects and noise
  task automatic queue_random_task(input int unsigned cost_shift);
    int unsigned roll;
    int unsigned period;
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      queue_task(1'b1, $urandom_range(0, 1023), $urandom_range(1, 1023));
    end else if (roll < 8) begin
      queue_task(1'b0, $urandom_range(0, 1023), 0);
    end else if (roll < 12) begin
      period = $urandom_range(0, 1022);
      queue_task(1'b0, $urandom_range(period + 1, 1023), period);
    end else if (roll < 15) begin
      queue_task($urandom_range(0, 1), $urandom_range(0, 1023), $urandom_range(0, 1023));
    end else begin
      period = $urandom_range(1, 1023);
      queue_task(1'b0, $urandom_range(0, period >> cost_shift), period);
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (task_backlog.size() != 0 || push || expected_placements.size() != 0);
  endtask

  task automatic write_active_count(input logic [CFG_W-1:0] value);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  // stimulus sequence
  initial begin
    int unsigned phase;
    int unsigned sweep;
    int unsigned set_len;
    int unsigned cost_shift;
    bit          fill_run;
    calm = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: error priority, clears, utilization extremes, tie-break
    queue_task(1'b1, 0, 0);
    queue_task(1'b0, 1023, 0);
    queue_task(1'b0, 1023, 1022);
    queue_task(1'b0, 1023, 1023);
    queue_task(1'b0, 0, 1023);
    queue_task(1'b0, 1, 1023);
    queue_task(1'b0, 1, 1);
    queue_task(1'b0, 341, 1023);
    queue_task(1'b0, 512, 1024 - 1);
    queue_task(1'b1, 5, 3);
    queue_task(1'b0, 1, 2);
    queue_task(1'b0, 1, 2);
    queue_task(1'b0, 682, 1023);
    queue_task(1'b0, 682, 1023);
    queue_task(1'b0, 1, 2);
    queue_task(1'b0, 1, 2);
    queue_task(1'b1, 7, 0);
    queue_task(1'b0, 1022, 1023);
    queue_task(1'b0, 513, 1023);
    queue_task(1'b0, 1023, 1023);
    queue_task(1'b0, 1023, 1023);
    queue_task(1'b0, 0, 1);

    // random task sets under a sweep of processor counts
    phase = 0;
    sweep = 0;
    while (request_total < TARGET_REQS) begin
      phase++;
      fill_run = (phase % 6 == 2);
      if (fill_run) begin
        write_active_count(CFG_W'($urandom_range(0, 1)));
      end else if (sweep < 8) begin
        write_active_count(CFG_W'(sweep));
        sweep++;
      end else begin
        write_active_count(CFG_W'($urandom_range(0, 7)));
      end
      calm = ($urandom_range(0, 3) == 0);
      if (fill_run) begin
        queue_task(1'b1, 0, $urandom_range(1, 1023));
        repeat (70) queue_task(1'b0, $urandom_range(0, 7), $urandom_range(8, 1023));
      end else begin
        cost_shift = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(2, 5);
        set_len    = $urandom_range(20, 80);
        queue_task(1'b1, $urandom_range(0, 255), $urandom_range(256, 1023));
        repeat (set_len) queue_random_task(cost_shift);
      end
    end

    wait_idle();
    repeat (50) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
